### hdl/keyed_record_table_lru_evict_core_assert.svh
// Assertion macros for the keyed record table RTL.
`ifndef KEYED_RECORD_TABLE_LRU_EVICT_CORE_ASSERT_SVH
`define KEYED_RECORD_TABLE_LRU_EVICT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked implication check with an asynchronous active-low reset.
`define KRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define KRT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define KRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define KRT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hdl/krt_pkg.sv
// Types, constants and helpers shared by the keyed record table modules.
`default_nettype none

package krt_pkg;

  localparam int SLOTS      = 8;
  localparam int NAME_LIMIT = 9;
  localparam int CELL_MAX   = 16;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int KEY_W   = 64;
  localparam int TIME_W  = 48;
  localparam int MEAS_W  = 64;
  localparam int CELLS_W = 8;
  localparam int CCNT_W  = 5;
  localparam int OIDX_W  = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    CMD_REC  = 2'd0,
    CMD_LOOK = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVAL    = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_KEEP  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // One input beat, unpacked.
  typedef struct packed {
    logic               func;
    logic [KEY_W-1:0]   name_key;
    logic [TIME_W-1:0]  now_time;
    logic [MEAS_W-1:0]  measurement_word;
    logic [CELLS_W-1:0] reported_cells;
    logic               cells_present;
    logic [CELLS_W-1:0] cells_carried;
  } in_item_t;

  // Classified command passed from the front to the back through the queue.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  now_time;
    logic [MEAS_W-1:0]  meas;
    logic [CELLS_W-1:0] rep;
    logic               present;
    logic [CELLS_W-1:0] carried;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    status_e            status;
    logic [OIDX_W-1:0]  slot_num;
    logic               evicted;
    action_e            cell_action;
    logic [MEAS_W-1:0]  stored_measurements;
    logic [CELLS_W-1:0] stored_reported_cells;
    logic               stored_cells_valid;
    logic [CCNT_W-1:0]  stored_cell_count;
    logic [TIME_W-1:0]  stored_seen_time;
    logic [TIME_W-1:0]  stored_cell_time;
  } result_t;

  // Slot index as reported on the result: low bits, zero extended.
  function automatic logic [OIDX_W-1:0] out_idx(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+OIDX_W-1:0] ext;
    ext = {{OIDX_W{1'b0}}, idx};
    return ext[OIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/keyed_record_table_lru_evict_core.sv
// Top level of the keyed record table with least-recently-seen eviction.
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | record or lookup beat
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | one result beat per input beat
//
// In the slot engine a record or lookup beat is first picked from the queue;
// the scan then reads a single slot each cycle until every slot is read, and
// a last step writes the slot for a record and loads the result register. A
// beat rejected by the front end goes straight from the pick to that last step.
// Reset clears the slot used flags at once, so no clearing pass is needed.
// The input side stalls only while the two-entry command queue is full; a
// finished result waits in the output register while the engine takes the
// next command and scans, and the engine waits in its last step only while
// that register is still full and not being taken.
`default_nettype none

module keyed_record_table_lru_evict_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: name_key[63:0], now_time[111:64],
  // measurement_word[175:112], reported_cells[183:176], cells_present[184],
  // cells_carried[192:185], zero fill[199:193].
  input  logic [199:0] s_axis_tdata,
  // Fields from bit 0: func[0].
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: slot_num[2:0], evicted[3], cell_action[5:4],
  // stored_measurements[69:6], stored_reported_cells[77:70],
  // stored_cells_valid[78], stored_cell_count[83:79],
  // stored_seen_time[131:84], stored_cell_time[179:132], zero fill[183:180].
  output logic [183:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]   m_axis_tuser
);
  import krt_pkg::*;

  in_item_t item;
  cmd_t     front_cmd;
  cmd_t     q_data;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  result_t  res;

  // Unpack the input beat into its fields.
  assign item.func             = s_axis_tuser;
  assign item.name_key         = s_axis_tdata[63:0];
  assign item.now_time         = s_axis_tdata[111:64];
  assign item.measurement_word = s_axis_tdata[175:112];
  assign item.reported_cells   = s_axis_tdata[183:176];
  assign item.cells_present    = s_axis_tdata[184];
  assign item.cells_carried    = s_axis_tdata[192:185];

  // The front end checks the name and the cell fields in the accepting cycle.
  krt_front u_front (
    .item_i (item),
    .cmd_o  (front_cmd)
  );

  assign s_axis_tready = !q_full;

  krt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .empty_o     (q_empty)
  );

  // The slot engine owns the table and the output register.
  krt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // Pack the result beat.
  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {4'b0000,
                         res.stored_cell_time,
                         res.stored_seen_time,
                         res.stored_cell_count,
                         res.stored_cells_valid,
                         res.stored_reported_cells,
                         res.stored_measurements,
                         res.cell_action,
                         res.evicted,
                         res.slot_num};

endmodule

`default_nettype wire

### hdl/krt_front.sv
// Front end: validates name and cell fields and classifies each beat.
`default_nettype none

module krt_front (
  input  krt_pkg::in_item_t item_i,
  output krt_pkg::cmd_t     cmd_o
);
  import krt_pkg::*;

  logic [7:0]       live;
  logic [7:0]       char_ok;
  logic [3:0]       name_len;
  logic [KEY_W-1:0] norm_key;
  logic             name_ok;
  logic             cells_bad;
  logic [7:0]       ch;

  always_comb begin
    live     = '0;
    char_ok  = '0;
    name_len = '0;
    norm_key = '0;
    ch       = '0;
    for (int i = 0; i < 8; i++) begin
      ch = item_i.name_key[8*i +: 8];
      if (i == 0) begin
        live[i] = (ch != 8'h00);
      end else begin
        live[i] = live[i-1] && (ch != 8'h00);
      end
      char_ok[i] = !live[i] || ((ch > CHAR_SPACE) && (ch <= CHAR_TILDE));
      norm_key[8*i +: 8] = live[i] ? ch : 8'h00;
      name_len = name_len + 4'(live[i]);
    end
    name_ok = live[0] && (&char_ok) && (name_len < 4'(NAME_LIMIT));
  end

  assign cells_bad = item_i.cells_present &&
                     ((item_i.cells_carried == '0) ||
                      (item_i.cells_carried > CELLS_W'(CELL_MAX)) ||
                      (item_i.cells_carried != item_i.reported_cells));

  always_comb begin
    cmd_o.key      = norm_key;
    cmd_o.now_time = item_i.now_time;
    cmd_o.meas     = item_i.measurement_word;
    cmd_o.rep      = item_i.reported_cells;
    cmd_o.present  = item_i.cells_present;
    cmd_o.carried  = item_i.cells_carried;
    if (!name_ok) begin
      cmd_o.kind = CMD_ERR;
    end else if (item_i.func) begin
      cmd_o.kind = CMD_LOOK;
    end else if (cells_bad) begin
      cmd_o.kind = CMD_ERR;
    end else begin
      cmd_o.kind = CMD_REC;
    end
  end

endmodule

`default_nettype wire

### hdl/krt_fifo.sv
// Short command queue between the front end and the slot engine.
`default_nettype none

module krt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  krt_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output krt_pkg::cmd_t pop_data_o,
  output logic          empty_o
);
  import krt_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/krt_back.sv
// Slot engine: scans the table, picks the target slot, writes it and drives the result.
`default_nettype none

`include "keyed_record_table_lru_evict_core_assert.svh"

module krt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  krt_pkg::cmd_t    q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output krt_pkg::result_t out_data_o
);
  import krt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  seen;
    logic [MEAS_W-1:0]  meas;
    logic [CELLS_W-1:0] rep;
  } slot_main_t;

  typedef struct packed {
    logic              cv;
    logic [CCNT_W-1:0] cc;
    logic [TIME_W-1:0] ctime;
  } slot_cell_t;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;

  slot_main_t       main_q [SLOTS];
  slot_cell_t       cell_q [SLOTS];
  logic [SLOTS-1:0] used_q;

  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              cnt_last;

  logic              match_q, match_d;
  logic [SLOT_W-1:0] match_idx_q, match_idx_d;
  slot_main_t        match_main_q, match_main_d;
  slot_cell_t        match_cell_q, match_cell_d;
  logic              free_q, free_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic [SLOT_W-1:0] min_idx_q, min_idx_d;
  slot_main_t        min_main_q, min_main_d;
  logic              min_cv_q, min_cv_d;

  slot_main_t        rd_main;
  slot_cell_t        rd_cell;
  logic              rd_used;

  logic              load;
  logic              wr_main, wr_cell;
  logic [SLOT_W-1:0] tgt;
  logic              evict;
  logic              keep;
  action_e           action;
  slot_main_t        new_main;
  slot_cell_t        new_cell;
  result_t           res;

  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  logic              in_scan;
  logic              in_done;
  logic              out_stall;

  assign cnt_last = (cnt_q == SLOT_W'(SLOTS-1));
  assign rd_main  = main_q[cnt_q];
  assign rd_cell  = cell_q[cnt_q];
  assign rd_used  = used_q[cnt_q];

  // Sequencer: pop, scan every slot once unless the command is an error, then finish.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_main_d = match_main_q;
    match_cell_d = match_cell_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    min_idx_d    = min_idx_q;
    min_main_d   = min_main_q;
    min_cv_d     = min_cv_q;
    q_pop_o      = 1'b0;
    load         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          state_d = (q_data_i.kind == CMD_ERR) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_used && (rd_main.key == cmd_q.key) && !match_q) begin
          match_d      = 1'b1;
          match_idx_d  = cnt_q;
          match_main_d = rd_main;
          match_cell_d = rd_cell;
        end
        if (!rd_used && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = cnt_q;
        end
        // Strict less-than keeps the lowest index on equal seen times.
        if ((cnt_q == '0) || (rd_main.seen < min_main_q.seen)) begin
          min_idx_d  = cnt_q;
          min_main_d = rd_main;
          min_cv_d   = rd_cell.cv;
        end
        if (cnt_last) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Target choice and preserve rule. The evicted slot is always in use.
  always_comb begin
    if (match_q) begin
      tgt   = match_idx_q;
      evict = 1'b0;
      keep  = match_cell_q.cv && (match_main_q.rep == cmd_q.rep);
    end else if (free_q) begin
      tgt   = free_idx_q;
      evict = 1'b0;
      keep  = 1'b0;
    end else begin
      tgt   = min_idx_q;
      evict = 1'b1;
      keep  = min_cv_q && (min_main_q.rep == cmd_q.rep);
    end
    if (cmd_q.present) begin
      action = ACT_WRITE;
    end else if (keep) begin
      action = ACT_KEEP;
    end else begin
      action = ACT_CLEAR;
    end
  end

  always_comb begin
    new_main.key  = cmd_q.key;
    new_main.seen = cmd_q.now_time;
    new_main.meas = cmd_q.meas;
    new_main.rep  = cmd_q.rep;
    if (action == ACT_WRITE) begin
      new_cell.cv    = 1'b1;
      new_cell.cc    = cmd_q.carried[CCNT_W-1:0];
      new_cell.ctime = cmd_q.now_time;
    end else begin
      new_cell = '0;
    end
  end

  assign wr_main = load && (cmd_q.kind == CMD_REC);
  assign wr_cell = wr_main && (action != ACT_KEEP);

  always_comb begin
    res             = '0;
    res.status      = STAT_OK;
    res.cell_action = ACT_WRITE;
    case (cmd_q.kind)
      CMD_REC: begin
        res.slot_num    = out_idx(tgt);
        res.evicted     = evict;
        res.cell_action = action;
      end
      CMD_LOOK: begin
        if (match_q) begin
          res.slot_num              = out_idx(match_idx_q);
          res.stored_measurements   = match_main_q.meas;
          res.stored_reported_cells = match_main_q.rep;
          res.stored_cells_valid    = match_cell_q.cv;
          res.stored_cell_count     = match_cell_q.cc;
          res.stored_seen_time      = match_main_q.seen;
          res.stored_cell_time      = match_cell_q.ctime;
        end else begin
          res.status = STAT_NOTFOUND;
        end
      end
      default: begin
        res.status = STAT_INVAL;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      cnt_q       <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      match_q     <= match_d;
      free_q      <= free_d;
      if (wr_main) begin
        used_q[tgt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    match_idx_q  <= match_idx_d;
    match_main_q <= match_main_d;
    match_cell_q <= match_cell_d;
    free_idx_q   <= free_idx_d;
    min_idx_q    <= min_idx_d;
    min_main_q   <= min_main_d;
    min_cv_q     <= min_cv_d;
    if (load) begin
      out_q <= res;
    end
    if (wr_main) begin
      main_q[tgt] <= new_main;
    end
    if (wr_cell) begin
      cell_q[tgt] <= new_cell;
    end
  end

  assign in_scan   = (state_q == S_SCAN);
  assign in_done   = (state_q == S_DONE);
  assign out_stall = out_valid_q && !out_ready_i;

  `KRT_ASSERT_CLK(a_scan_ends, clk_i, rst_ni, (in_scan && cnt_last) |=> in_done, "scan overran")
  `KRT_ASSERT_CLK(a_done_waits, clk_i, rst_ni, (in_done && out_stall) |=> in_done, "result dropped")
  `KRT_ASSERT_CLK(a_slot_used, clk_i, rst_ni, wr_main |=> used_q[$past(tgt)], "slot not marked used")
  `KRT_ASSERT_NEVER(a_err_no_scan, clk_i, rst_ni, in_scan && (cmd_q.kind == CMD_ERR), "bad item scanned")

endmodule

`default_nettype wire
